// ----- hdl/bmhpq_pkg.sv -----
// ----------------------------------------------------------------------------
// bmhpq_pkg
// Shared constants, types and codes of the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package bmhpq_pkg;

  // Heap geometry and field widths
  localparam int unsigned HEAP_DEPTH = 1024;
  localparam int unsigned KEY_WIDTH  = 32;
  localparam int unsigned TAG_WIDTH  = 16;
  localparam int unsigned ENTRY_W    = KEY_WIDTH + TAG_WIDTH;
  localparam int unsigned ADDR_W     = $clog2(HEAP_DEPTH);
  localparam int unsigned CNT_W      = $clog2(HEAP_DEPTH + 1);

  // One stored heap entry
  typedef struct packed {
    logic [KEY_WIDTH-1:0] key;
    logic [TAG_WIDTH-1:0] tag;
  } entry_t;

  // Request codes
  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_RM_WAIT,
    S_DN_CHK,
    S_DN_CMP
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic    req_clr;  // clear result, load status code
    status_e status;
    logic    ins_load; // take new entry, pos = count+1, count++
    logic    rd_up;    // read parent of pos on port A
    logic    rd_root;  // read root on A, last entry on B
    logic    rm_load;  // latch removed root, hold last entry, count--
    logic    rd_kids;  // read both children of pos
    logic    wr_self;  // write held entry at pos
    logic    up_move;  // write parent at pos, pos = pos/2
    logic    dn_move;  // write larger child at pos, pos = child
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic at_root;
    logic parent_le;
    logic has_kids;
    logic dn_stop;
    logic last_one;
  } stat_t;

endpackage

// ----- hdl/bmhpq_ram.sv -----
// ----------------------------------------------------------------------------
// bmhpq_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module bmhpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ----- hdl/bmhpq_datapath.sv -----
// ----------------------------------------------------------------------------
// bmhpq_datapath
// Heap storage, entry count, sift position, held entry and result registers.
// ----------------------------------------------------------------------------
module bmhpq_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [bmhpq_pkg::KEY_WIDTH-1:0] entry_key_i,
  input  logic [bmhpq_pkg::TAG_WIDTH-1:0] entry_tag_i,
  input  bmhpq_pkg::cmd_t                 cmd_i,
  output bmhpq_pkg::stat_t                stat_o,
  output logic                            out_valid_o,
  output logic [bmhpq_pkg::KEY_WIDTH-1:0] out_key_o,
  output logic [bmhpq_pkg::TAG_WIDTH-1:0] out_tag_o,
  output logic [1:0]                      status_o,
  output logic [bmhpq_pkg::CNT_W-1:0]     count_after_o
);

  localparam int unsigned CW = bmhpq_pkg::CNT_W;
  localparam int unsigned AW = bmhpq_pkg::ADDR_W;

  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      pos_q, pos_d;
  bmhpq_pkg::entry_t  held_q, held_d;
  logic               res_valid_q, res_valid_d;
  bmhpq_pkg::entry_t  res_q, res_d;
  bmhpq_pkg::status_e res_status_q, res_status_d;

  logic [AW-1:0]      raddr_a, raddr_b, waddr;
  logic [bmhpq_pkg::ENTRY_W-1:0] rdata_a, rdata_b, wdata;
  bmhpq_pkg::entry_t  rd_a, rd_b, child;
  logic               we;
  logic [CW:0]        kid_pos;   // 2*pos, one bit wider
  logic [CW-1:0]      parent_pos;
  logic               right_ok, take_right;
  logic [CW-1:0]      child_pos;

  assign rd_a = rdata_a;
  assign rd_b = rdata_b;

  // Position arithmetic
  assign parent_pos = pos_q >> 1;
  assign kid_pos    = {pos_q, 1'b0};
  assign right_ok   = kid_pos < {1'b0, count_q};
  assign take_right = right_ok && (rd_a.key < rd_b.key);
  assign child      = take_right ? rd_b : rd_a;
  assign child_pos  = take_right ? CW'(kid_pos + 1'b1) : CW'(kid_pos);

  // Read address selection (positions are 1-based)
  always_comb begin
    raddr_a = '0;
    raddr_b = '0;
    if (cmd_i.rd_root) begin
      // root sits at address 0, last entry on port B
      raddr_b = AW'(count_q - 1'b1);
    end else if (cmd_i.rd_up) begin
      raddr_a = AW'(parent_pos - 1'b1);
    end else if (cmd_i.rd_kids) begin
      raddr_a = AW'(kid_pos - 1'b1);
      raddr_b = AW'(kid_pos);
    end
  end

  // Write port
  assign we    = cmd_i.wr_self | cmd_i.up_move | cmd_i.dn_move;
  assign waddr = AW'(pos_q - 1'b1);
  always_comb begin
    wdata = held_q;
    if (cmd_i.up_move) begin
      wdata = rd_a;
    end else if (cmd_i.dn_move) begin
      wdata = child;
    end
  end

  bmhpq_ram #(
    .WIDTH(bmhpq_pkg::ENTRY_W),
    .DEPTH(bmhpq_pkg::HEAP_DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .rdata_a_o(rdata_a),
    .raddr_b_i(raddr_b),
    .rdata_b_o(rdata_b)
  );

  // Next-state of count, position, held entry and result
  always_comb begin
    count_d      = count_q;
    pos_d        = pos_q;
    held_d       = held_q;
    res_valid_d  = res_valid_q;
    res_d        = res_q;
    res_status_d = res_status_q;
    if (cmd_i.req_clr) begin
      res_valid_d  = 1'b0;
      res_d        = '0;
      res_status_d = cmd_i.status;
    end
    if (cmd_i.ins_load) begin
      held_d.key = entry_key_i;
      held_d.tag = entry_tag_i;
      count_d    = count_q + 1'b1;
      pos_d      = count_q + 1'b1;
    end
    if (cmd_i.rm_load) begin
      res_valid_d = 1'b1;
      res_d       = rd_a;
      held_d      = rd_b;
      count_d     = count_q - 1'b1;
      pos_d       = CW'(1);
    end
    if (cmd_i.up_move) begin
      pos_d = parent_pos;
    end
    if (cmd_i.dn_move) begin
      pos_d = child_pos;
    end
  end

  // Entry count is control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    held_q       <= held_d;
    res_valid_q  <= res_valid_d;
    res_q        <= res_d;
    res_status_q <= res_status_d;
  end

  // Status to controller
  assign stat_o.full      = count_q == CW'(bmhpq_pkg::HEAP_DEPTH);
  assign stat_o.empty     = count_q == '0;
  assign stat_o.at_root   = pos_q == CW'(1);
  assign stat_o.parent_le = rd_a.key <= held_q.key;
  assign stat_o.has_kids  = kid_pos <= {1'b0, count_q};
  assign stat_o.dn_stop   = held_q.key >= child.key;
  assign stat_o.last_one  = count_q == CW'(1);

  // Result ports
  assign out_valid_o   = res_valid_q;
  assign out_key_o     = res_q.key;
  assign out_tag_o     = res_q.tag;
  assign status_o      = res_status_q;
  assign count_after_o = count_q;

endmodule

// ----- hdl/bmhpq_ctrl.sv -----
// ----------------------------------------------------------------------------
// bmhpq_ctrl
// Controller: sequences insert sift-up and remove sift-down over the heap RAM.
// ----------------------------------------------------------------------------
module bmhpq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              req_type_i,
  input  bmhpq_pkg::stat_t  stat_i,
  output bmhpq_pkg::cmd_t   cmd_o,
  output logic              busy,
  output logic              done_o
);

  bmhpq_pkg::state_e state_q, state_d;
  logic              done_q, done_d;

  // State and strobe registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmhpq_pkg::S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    done_d       = 1'b0;
    cmd_o        = '0;
    cmd_o.status = bmhpq_pkg::ST_OK;
    unique case (state_q)
      bmhpq_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.req_clr = 1'b1;
          if (req_type_i == bmhpq_pkg::REQ_INSERT) begin
            if (stat_i.full) begin
              cmd_o.status = bmhpq_pkg::ST_FULL;
              done_d       = 1'b1;
            end else begin
              cmd_o.ins_load = 1'b1;
              state_d        = bmhpq_pkg::S_UP_CHK;
            end
          end else begin
            if (stat_i.empty) begin
              cmd_o.status = bmhpq_pkg::ST_EMPTY;
              done_d       = 1'b1;
            end else begin
              cmd_o.rd_root = 1'b1;
              state_d       = bmhpq_pkg::S_RM_WAIT;
            end
          end
        end
      end
      // Sift up: fetch parent unless at root
      bmhpq_pkg::S_UP_CHK: begin
        if (stat_i.at_root) begin
          cmd_o.wr_self = 1'b1;
          done_d        = 1'b1;
          state_d       = bmhpq_pkg::S_IDLE;
        end else begin
          cmd_o.rd_up = 1'b1;
          state_d     = bmhpq_pkg::S_UP_CMP;
        end
      end
      // Parent not greater: it moves down one level
      bmhpq_pkg::S_UP_CMP: begin
        if (stat_i.parent_le) begin
          cmd_o.up_move = 1'b1;
          state_d       = bmhpq_pkg::S_UP_CHK;
        end else begin
          cmd_o.wr_self = 1'b1;
          done_d        = 1'b1;
          state_d       = bmhpq_pkg::S_IDLE;
        end
      end
      // Root and last entry arrive from the RAM
      bmhpq_pkg::S_RM_WAIT: begin
        cmd_o.rm_load = 1'b1;
        if (stat_i.last_one) begin
          done_d  = 1'b1;
          state_d = bmhpq_pkg::S_IDLE;
        end else begin
          state_d = bmhpq_pkg::S_DN_CHK;
        end
      end
      // Sift down: fetch both children while any exist
      bmhpq_pkg::S_DN_CHK: begin
        if (stat_i.has_kids) begin
          cmd_o.rd_kids = 1'b1;
          state_d       = bmhpq_pkg::S_DN_CMP;
        end else begin
          cmd_o.wr_self = 1'b1;
          done_d        = 1'b1;
          state_d       = bmhpq_pkg::S_IDLE;
        end
      end
      // Larger child moves up unless held entry is at least as large
      bmhpq_pkg::S_DN_CMP: begin
        if (stat_i.dn_stop) begin
          cmd_o.wr_self = 1'b1;
          done_d        = 1'b1;
          state_d       = bmhpq_pkg::S_IDLE;
        end else begin
          cmd_o.dn_move = 1'b1;
          state_d       = bmhpq_pkg::S_DN_CHK;
        end
      end
      default: begin
        state_d = bmhpq_pkg::S_IDLE;
      end
    endcase
  end

  assign busy   = state_q != bmhpq_pkg::S_IDLE;
  assign done_o = done_q;

endmodule

// ----- hdl/binary_max_heap_priority_queue.sv -----
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue
// Max-heap priority queue of key/tag entries with insert and remove-largest.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Exactly one result
// follows per request, shown for a single cycle with done_o high; the
// receiver cannot stall it and must take it in that cycle. Errors (insert
// when full, remove when empty) answer in the cycle after the request.
// Otherwise the heap is walked level by level, each level a RAM read then a
// compare and write. A new request may be started in the cycle its
// predecessor's result is shown.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            req_type_i,
  input  logic [bmhpq_pkg::KEY_WIDTH-1:0] entry_key_i,
  input  logic [bmhpq_pkg::TAG_WIDTH-1:0] entry_tag_i,
  output logic                            done_o,
  output logic                            out_valid_o,
  output logic [bmhpq_pkg::KEY_WIDTH-1:0] out_key_o,
  output logic [bmhpq_pkg::TAG_WIDTH-1:0] out_tag_o,
  output logic [1:0]                      status_o,
  output logic [bmhpq_pkg::CNT_W-1:0]     count_after_o
);

  bmhpq_pkg::cmd_t  cmd;
  bmhpq_pkg::stat_t stat;

  bmhpq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .req_type_i(req_type_i),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .busy      (busy),
    .done_o    (done_o)
  );

  bmhpq_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_key_i  (entry_key_i),
    .entry_tag_i  (entry_tag_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .out_key_o    (out_key_o),
    .out_tag_o    (out_tag_o),
    .status_o     (status_o),
    .count_after_o(count_after_o)
  );

endmodule
